@@ rtl/core/edge_interrupt_controller_core_defines.svh @@
// Assertion macros for the edge interrupt controller core.
// Included by the RTL files that carry concurrent checks; no other dependencies.
// The checks compile away when SYNTHESIS is defined.
`ifndef EDGE_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH
`define EDGE_INTERRUPT_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication check
`define EIC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edge interrupt controller: same-cycle check failed");

// Next-cycle implication check
`define EIC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("edge interrupt controller: next-cycle check failed");

`else

`define EIC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define EIC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/core/eic_pkg.sv @@
// Shared constants, register map codes and types of the edge interrupt controller.
// No dependencies; every other RTL file imports it.
`timescale 1ns / 1ps

package eic_pkg;

   // Sizing
   localparam int NUM_LINES      = 16;  // 1..16
   localparam int NUM_PORTS      = 4;   // 1..4
   localparam int MAX_LINES      = 16;
   localparam int PORT_LINES     = 16;
   localparam int SEL_W          = 8;
   localparam int LINES_PER_WORD = 4;
   localparam int SEL_WORD_W     = 2;
   localparam int LINE_IDX_W     = 4;
   localparam int REQ_W          = 2;
   localparam int ADDR_W         = 4;
   localparam int DATA_W         = 32;
   localparam int GPIO_W         = 64;
   localparam int IRQ_W          = 16;

   // Request kinds
   localparam logic [REQ_W-1:0] REQ_READ  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_WRITE = 2'd1;
   localparam logic [REQ_W-1:0] REQ_TICK  = 2'd2;

   // Register map
   localparam logic [ADDR_W-1:0] ADDR_RISE_EN   = 4'd0;
   localparam logic [ADDR_W-1:0] ADDR_FALL_EN   = 4'd1;
   localparam logic [ADDR_W-1:0] ADDR_RISE_PEND = 4'd2;
   localparam logic [ADDR_W-1:0] ADDR_FALL_PEND = 4'd3;
   localparam logic [ADDR_W-1:0] ADDR_MASK      = 4'd4;
   localparam logic [ADDR_W-1:0] ADDR_SECURE    = 4'd5;
   localparam logic [ADDR_W-1:0] ADDR_PRIV      = 4'd6;
   localparam logic [ADDR_W-1:0] ADDR_SEL0      = 4'd7;
   localparam logic [ADDR_W-1:0] ADDR_SEL1      = 4'd8;
   localparam logic [ADDR_W-1:0] ADDR_SEL2      = 4'd9;
   localparam logic [ADDR_W-1:0] ADDR_SEL3      = 4'd10;

   typedef logic [NUM_LINES-1:0] line_vec_type;
   typedef logic [NUM_LINES-1:0][SEL_W-1:0] port_sel_array_type;

   typedef struct packed {
      logic [REQ_W-1:0]  req_type;
      logic [ADDR_W-1:0] reg_addr;
      logic [DATA_W-1:0] write_data;
      logic [GPIO_W-1:0] gpio_levels;
   } eic_item_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [IRQ_W-1:0]  irq_lines;
      logic              bad_address;
   } eic_result_type;

endpackage

@@ rtl/core/eic_channel_if.sv @@
// Valid/ready channel interfaces for the request and response sides.
// Depends on eic_pkg for field widths.
`timescale 1ns / 1ps

interface eic_req_if;
   import eic_pkg::*;

   logic              valid;
   logic              ready;
   logic [REQ_W-1:0]  req_type;
   logic [ADDR_W-1:0] reg_addr;
   logic [DATA_W-1:0] write_data;
   logic [GPIO_W-1:0] gpio_levels;

   modport source (output valid, req_type, reg_addr, write_data, gpio_levels,
                   input ready);
   modport sink   (input valid, req_type, reg_addr, write_data, gpio_levels,
                   output ready);
endinterface

interface eic_rsp_if;
   import eic_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;
   logic [IRQ_W-1:0]  irq_lines;
   logic              bad_address;

   modport source (output valid, read_data, irq_lines, bad_address, input ready);
   modport sink   (input valid, read_data, irq_lines, bad_address, output ready);
endinterface

@@ rtl/core/eic_line_sampler.sv @@
// Per-line level pick: each line takes its bit from the GPIO port it selects.
// Depends on eic_pkg.
`timescale 1ns / 1ps

module eic_line_sampler (
   input  logic [eic_pkg::GPIO_W-1:0]       gpio_levels,
   input  eic_pkg::port_sel_array_type      port_sel,
   output eic_pkg::line_vec_type            level
);
   import eic_pkg::*;

   // Pick bit i of the selected port; an out-of-range port reads low
   always_comb begin
      level = '0;
      for (int i = 0; i < NUM_LINES; i++) begin
         for (int q = 0; q < NUM_PORTS; q++) begin
            if (port_sel[i] == SEL_W'(q)) begin
               level[i] = gpio_levels[q * PORT_LINES + i];
            end
         end
      end
   end

endmodule

@@ rtl/core/eic_reg_file.sv @@
// Control and status registers, pending logic and edge detection.
// Depends on eic_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "edge_interrupt_controller_core_defines.svh"

module eic_reg_file (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  eic_pkg::eic_item_type       item,
   input  eic_pkg::line_vec_type       level,
   output eic_pkg::port_sel_array_type port_sel,
   output eic_pkg::eic_result_type     result
);
   import eic_pkg::*;

   line_vec_type       rise_en_ff,   rise_en_in;
   line_vec_type       fall_en_ff,   fall_en_in;
   line_vec_type       rise_pend_ff, rise_pend_in;
   line_vec_type       fall_pend_ff, fall_pend_in;
   line_vec_type       mask_ff,      mask_in;
   line_vec_type       secure_ff,    secure_in;
   line_vec_type       priv_ff,      priv_in;
   line_vec_type       prev_ff,      prev_in;
   port_sel_array_type port_sel_ff,  port_sel_in;

   logic                  is_read;
   logic                  is_write;
   logic                  is_tick;
   logic                  addr_ok;
   line_vec_type          wr_bits;
   line_vec_type          rise;
   line_vec_type          fall;
   logic [SEL_WORD_W-1:0] sel_word;
   logic [SEL_W-1:0]      sel_view [MAX_LINES];
   logic [DATA_W-1:0]     sel_word_data;
   logic [DATA_W-1:0]     rd_data;

   assign port_sel = port_sel_ff;

   // Decode the request
   assign is_read  = (item.req_type == REQ_READ);
   assign is_write = (item.req_type == REQ_WRITE);
   assign is_tick  = (item.req_type == REQ_TICK);
   assign addr_ok  = (item.reg_addr <= ADDR_SEL3);
   assign wr_bits  = item.write_data[NUM_LINES-1:0];
   assign sel_word = SEL_WORD_W'(item.reg_addr - ADDR_SEL0);

   // Edges against the previous sample
   assign rise = level & ~prev_ff;
   assign fall = ~level & prev_ff;

   // Port fields of absent lines read as zero
   for (genvar j = 0; j < MAX_LINES; j++) begin : g_sel_view
      if (j < NUM_LINES) begin : g_present
         assign sel_view[j] = port_sel_ff[j];
      end else begin : g_absent
         assign sel_view[j] = '0;
      end
   end

   // Assemble one port-select word, four lines per word
   always_comb begin
      sel_word_data = '0;
      for (int k = 0; k < LINES_PER_WORD; k++) begin
         sel_word_data[k * SEL_W +: SEL_W] =
            sel_view[{sel_word, SEL_WORD_W'(k)}];
      end
   end

   // Read mux
   always_comb begin
      rd_data = '0;
      if (is_read) begin
         case (item.reg_addr)
            ADDR_RISE_EN:   rd_data = DATA_W'(rise_en_ff);
            ADDR_FALL_EN:   rd_data = DATA_W'(fall_en_ff);
            ADDR_RISE_PEND: rd_data = DATA_W'(rise_pend_ff);
            ADDR_FALL_PEND: rd_data = DATA_W'(fall_pend_ff);
            ADDR_MASK:      rd_data = DATA_W'(mask_ff);
            ADDR_SECURE:    rd_data = DATA_W'(secure_ff);
            ADDR_PRIV:      rd_data = DATA_W'(priv_ff);
            ADDR_SEL0, ADDR_SEL1, ADDR_SEL2, ADDR_SEL3: rd_data = sel_word_data;
            default:        rd_data = '0;
         endcase
      end
   end

   // Next state: bus writes, write-one-to-clear, tick sampling
   always_comb begin
      rise_en_in   = rise_en_ff;
      fall_en_in   = fall_en_ff;
      rise_pend_in = rise_pend_ff;
      fall_pend_in = fall_pend_ff;
      mask_in      = mask_ff;
      secure_in    = secure_ff;
      priv_in      = priv_ff;
      prev_in      = prev_ff;
      port_sel_in  = port_sel_ff;
      if (is_write) begin
         case (item.reg_addr)
            ADDR_RISE_EN:   rise_en_in   = wr_bits;
            ADDR_FALL_EN:   fall_en_in   = wr_bits;
            ADDR_RISE_PEND: rise_pend_in = rise_pend_ff & ~wr_bits;
            ADDR_FALL_PEND: fall_pend_in = fall_pend_ff & ~wr_bits;
            ADDR_MASK:      mask_in      = wr_bits;
            ADDR_SECURE:    secure_in    = wr_bits;
            ADDR_PRIV:      priv_in      = wr_bits;
            ADDR_SEL0, ADDR_SEL1, ADDR_SEL2, ADDR_SEL3: begin
               for (int j = 0; j < NUM_LINES; j++) begin
                  if (sel_word == SEL_WORD_W'(j / LINES_PER_WORD)) begin
                     port_sel_in[j] =
                        item.write_data[(j % LINES_PER_WORD) * SEL_W +: SEL_W];
                  end
               end
            end
            default: ;
         endcase
      end
      if (is_tick) begin
         rise_pend_in = rise_pend_ff | (rise & rise_en_ff);
         fall_pend_in = fall_pend_ff | (fall & fall_en_ff);
         prev_in      = level;
      end
   end

   // Result of this item: read data before the update, interrupt lines after it
   assign result.read_data   = rd_data;
   assign result.irq_lines   = IRQ_W'((rise_pend_in | fall_pend_in) & mask_in);
   assign result.bad_address = (is_read || is_write) && !addr_ok;

   // Update state when the item advances
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_en_ff   <= '0;
         fall_en_ff   <= '0;
         rise_pend_ff <= '0;
         fall_pend_ff <= '0;
         mask_ff      <= '0;
         secure_ff    <= '0;
         priv_ff      <= '0;
         prev_ff      <= '0;
         port_sel_ff  <= '0;
      end else if (fire) begin
         rise_en_ff   <= rise_en_in;
         fall_en_ff   <= fall_en_in;
         rise_pend_ff <= rise_pend_in;
         fall_pend_ff <= fall_pend_in;
         mask_ff      <= mask_in;
         secure_ff    <= secure_in;
         priv_ff      <= priv_in;
         prev_ff      <= prev_in;
         port_sel_ff  <= port_sel_in;
      end
   end

   // Pending bits are set only by a tick
   `EIC_ASSERT_NEXT(a_rise_set_on_tick, clock, reset, !(fire && is_tick),
      (rise_pend_ff & ~$past(rise_pend_ff)) == '0)
   `EIC_ASSERT_NEXT(a_fall_set_on_tick, clock, reset, !(fire && is_tick),
      (fall_pend_ff & ~$past(fall_pend_ff)) == '0)
   // Previous level moves only on a tick
   `EIC_ASSERT_NEXT(a_prev_on_tick, clock, reset, !(fire && is_tick), $stable(prev_ff))

endmodule

@@ rtl/core/edge_interrupt_controller_core.sv @@
// Edge interrupt controller core: 16 lines, bus access and pin sampling.
// Request/response channels are valid/ready interfaces; one response per request.
// An accepted request passes through the input register, then the result
// register, before its response is valid. One request per cycle is accepted
// while the response receiver keeps rsp_chan.ready high.
// Each request is a register read, a register write or a pin sample tick.
// The response carries the read data, the interrupt lines after the update
// and a bad-address flag. Pins are sampled only on tick requests.
// Reset (synchronous, active high) clears the control and status registers and
// stage flags, not the item and result data: all lines masked, triggers off,
// no pending, port 0 selected, previous levels low, both pipeline stages empty.
// A stalled response receiver holds the result register; the input register
// keeps one more request, after which req_chan.ready drops until the
// response is taken.
// Depends on eic_pkg, eic_channel_if, eic_line_sampler, eic_reg_file.
`timescale 1ns / 1ps
`include "edge_interrupt_controller_core_defines.svh"

module edge_interrupt_controller_core (
   input  logic           clock,
   input  logic           reset,
   eic_req_if.sink        req_chan,
   eic_rsp_if.source      rsp_chan
);
   import eic_pkg::*;

   logic               s1_valid_ff, s1_valid_in;
   eic_item_type       s1_item_ff;
   logic               out_valid_ff, out_valid_in;
   eic_result_type     out_result_ff;
   logic               req_fire;
   logic               advance;
   eic_item_type       req_item;
   eic_result_type     result;
   line_vec_type       level;
   port_sel_array_type port_sel;

   // Handshake
   assign advance        = s1_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || advance;
   assign req_fire       = req_chan.valid && req_chan.ready;

   assign req_item.req_type    = req_chan.req_type;
   assign req_item.reg_addr    = req_chan.reg_addr;
   assign req_item.write_data  = req_chan.write_data;
   assign req_item.gpio_levels = req_chan.gpio_levels;

   // Stage flags
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the item and hold the result
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff <= req_item;
      end
      if (advance) begin
         out_result_ff <= result;
      end
   end

   eic_line_sampler u_sampler (
      .gpio_levels (s1_item_ff.gpio_levels),
      .port_sel    (port_sel),
      .level       (level)
   );

   eic_reg_file u_regs (
      .clock    (clock),
      .reset    (reset),
      .fire     (advance),
      .item     (s1_item_ff),
      .level    (level),
      .port_sel (port_sel),
      .result   (result)
   );

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.read_data   = out_result_ff.read_data;
   assign rsp_chan.irq_lines   = out_result_ff.irq_lines;
   assign rsp_chan.bad_address = out_result_ff.bad_address;

   // An advancing item always lands in the result register
   `EIC_ASSERT_NEXT(a_advance_fills_out, clock, reset, advance, out_valid_ff)
   // A blocked item stays put
   `EIC_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !advance,
      s1_valid_ff && $stable(s1_item_ff))
   // A bad address never returns read data
   `EIC_ASSERT_IMPLY(a_bad_no_data, clock, reset,
      out_valid_ff && out_result_ff.bad_address, out_result_ff.read_data == '0)

endmodule
